// ----- rtl/brm_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// brm_pkg: shared types and constants for the box region mask block
// Command codes, frame geometry, the box entry and the query token that
// walks the cell chain.
// ----------------------------------------------------------------------------
package brm_pkg;

    localparam int MAX_BOXES_DEF = 16;
    localparam int COORD_BITS    = 12;
    localparam int OBJ_W         = 4;

    localparam logic [1:0] CMD_CLEAR    = 2'd0;
    localparam logic [1:0] CMD_APPEND   = 2'd1;
    localparam logic [1:0] CMD_PIXEL    = 2'd2;
    localparam logic [1:0] CMD_KEYPOINT = 2'd3;

    localparam logic KIND_PIXEL    = 1'b0;
    localparam logic KIND_KEYPOINT = 1'b1;

    typedef struct packed {
        logic signed [12:0] left;
        logic signed [12:0] top;
        logic [11:0]        span_x;
        logic [11:0]        span_y;
    } t_box;

    typedef struct packed {
        logic             valid;
        logic             kind;
        logic [11:0]      col;
        logic [11:0]      row;
        logic [7:0]       value;
        logic [15:0]      px;
        logic [15:0]      py;
        logic [15:0]      number;
        logic             hit;
        logic [OBJ_W-1:0] obj;
    } t_tok;

endpackage
`default_nettype wire

// ----- rtl/brm_cell.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// brm_cell: one box slot of the chain
// Holds one box and its valid flag, tests the passing token against it and
// hands the token to the next cell through its output register.
// ----------------------------------------------------------------------------
module brm_cell
    import brm_pkg::*;
#(
    parameter int INDEX = 0
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_clear,
    input  wire logic i_wr_en,
    input  wire t_box i_box,
    input  wire t_tok i_tok,
    output t_tok      o_tok
);

    localparam logic [14:0]      FRAME   = 15'(1 << COORD_BITS);
    localparam logic [OBJ_W-1:0] OBJ_NUM = OBJ_W'(INDEX % (1 << OBJ_W));

    logic r_valid;
    t_box r_box;
    t_tok r_tok;
    t_tok n_tok;

    logic signed [14:0] x_lo, x_hi, y_lo, y_hi, col_s, row_s;
    logic signed [19:0] kx_lo, kx_hi, ky_lo, ky_hi, px_s, py_s;
    logic               pix_in, pt_in, match;

    always_comb begin
        x_lo  = {{2{r_box.left[12]}}, r_box.left};
        y_lo  = {{2{r_box.top[12]}}, r_box.top};
        x_hi  = x_lo + $signed({3'b000, r_box.span_x});
        y_hi  = y_lo + $signed({3'b000, r_box.span_y});
        col_s = $signed({3'b000, i_tok.col});
        row_s = $signed({3'b000, i_tok.row});
        // clamping the low edge at zero is implied: the pixel is never negative
        pix_in = (col_s >= x_lo) && (col_s < x_hi) && ({3'b000, i_tok.col} < FRAME)
              && (row_s >= y_lo) && (row_s < y_hi) && ({3'b000, i_tok.row} < FRAME);
        kx_lo = {{3{r_box.left[12]}}, r_box.left, 4'b0000};
        ky_lo = {{3{r_box.top[12]}}, r_box.top, 4'b0000};
        kx_hi = {x_hi[14], x_hi, 4'b0000};
        ky_hi = {y_hi[14], y_hi, 4'b0000};
        px_s  = $signed({4'b0000, i_tok.px});
        py_s  = $signed({4'b0000, i_tok.py});
        pt_in = (px_s >= kx_lo) && (px_s <= kx_hi) && (py_s >= ky_lo) && (py_s <= ky_hi);
        match = r_valid && !i_tok.hit
             && ((i_tok.kind == KIND_KEYPOINT) ? pt_in : pix_in);

        n_tok = i_tok;
        if (match) begin
            n_tok.hit = 1'b1;
            n_tok.obj = OBJ_NUM;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            if (i_clear) begin
                r_valid <= 1'b0;
            end else if (i_wr_en) begin
                r_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_box <= i_box;
        end
        if (!i_rst_n) begin
            r_tok.valid <= 1'b0;
        end else begin
            r_tok.valid <= n_tok.valid;
        end
        r_tok.kind   <= n_tok.kind;
        r_tok.col    <= n_tok.col;
        r_tok.row    <= n_tok.row;
        r_tok.value  <= n_tok.value;
        r_tok.px     <= n_tok.px;
        r_tok.py     <= n_tok.py;
        r_tok.number <= n_tok.number;
        r_tok.hit    <= n_tok.hit;
        r_tok.obj    <= n_tok.obj;
    end

    assign o_tok = r_tok;

endmodule
`default_nettype wire

// ----- rtl/box_region_mask_and_assign_top.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// box_region_mask_and_assign_top: box table with pixel mask and keypoint
// assignment
// Keeps up to MAX_BOXES boxes; masks pixels by the boxes and assigns
// keypoints to the first containing box.
// ----------------------------------------------------------------------------
// Usage: issue a command by raising start while busy is low; the transfer
// happens on that clock edge. Clear and append take effect at once, give no
// result and never raise busy, so they can be issued every cycle. A pixel or
// keypoint query raises busy and walks the chain of MAX_BOXES box cells, one
// cell per cycle; its single result appears on the o_ ports with o_strobe
// high for exactly one cycle once the token leaves the last cell, and busy
// drops in that same cycle so the next command can follow at once. How long
// a query holds busy is set by the length of the cell chain. The receiver
// cannot stall: capture the result while o_strobe is high. Pixels use
// half-open box bounds clipped to the frame (2^COORD_BITS square) and pass
// unchanged when the table is empty; keypoints are in 1/16 pixel with
// inclusive, unclipped bounds.
// ----------------------------------------------------------------------------
module box_region_mask_and_assign_top
    import brm_pkg::*;
#(
    parameter int MAX_BOXES = MAX_BOXES_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic [1:0]         i_command,
    input  wire logic signed [12:0] i_box_left,
    input  wire logic signed [12:0] i_box_top,
    input  wire logic [11:0]        i_box_span_x,
    input  wire logic [11:0]        i_box_span_y,
    input  wire logic [11:0]        i_pixel_column,
    input  wire logic [11:0]        i_pixel_row,
    input  wire logic [7:0]         i_pixel_value,
    input  wire logic [15:0]        i_point_x,
    input  wire logic [15:0]        i_point_y,
    input  wire logic [15:0]        i_point_number,
    output logic                    o_strobe,
    output logic                    o_result_kind,
    output logic [7:0]              o_pixel_out,
    output logic                    o_point_hit,
    output logic [OBJ_W-1:0]        o_object_number,
    output logic [15:0]             o_point_number_out
);

    localparam int CNT_W = $clog2(MAX_BOXES + 1);

    logic             accept, is_query, do_clear, do_append;
    logic [CNT_W-1:0] r_count, n_count;
    logic             r_busy, n_busy;
    t_tok             r_tok, n_tok;
    t_box             new_box;
    t_tok             w_tok [0:MAX_BOXES];
    t_tok             last;

    assign accept    = start && !r_busy;
    assign is_query  = (i_command == CMD_PIXEL) || (i_command == CMD_KEYPOINT);
    assign do_clear  = accept && (i_command == CMD_CLEAR);
    // drop an append to a full table
    assign do_append = accept && (i_command == CMD_APPEND)
                    && (r_count < CNT_W'(MAX_BOXES));

    assign new_box.left   = i_box_left;
    assign new_box.top    = i_box_top;
    assign new_box.span_x = i_box_span_x;
    assign new_box.span_y = i_box_span_y;

    always_comb begin
        n_count = r_count;
        if (do_clear) begin
            n_count = '0;
        end else if (do_append) begin
            n_count = r_count + CNT_W'(1);
        end

        // hold busy from the query transfer until the last cell loads
        n_busy = r_busy;
        if (accept && is_query) begin
            n_busy = 1'b1;
        end else if (w_tok[MAX_BOXES-1].valid) begin
            n_busy = 1'b0;
        end

        // seed the token: an empty table keeps every pixel
        n_tok.valid  = accept && is_query;
        n_tok.kind   = (i_command == CMD_KEYPOINT) ? KIND_KEYPOINT : KIND_PIXEL;
        n_tok.col    = i_pixel_column;
        n_tok.row    = i_pixel_row;
        n_tok.value  = i_pixel_value;
        n_tok.px     = i_point_x;
        n_tok.py     = i_point_y;
        n_tok.number = i_point_number;
        n_tok.hit    = (i_command == CMD_PIXEL) && (r_count == '0);
        n_tok.obj    = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_busy  <= 1'b0;
        end else begin
            r_count <= n_count;
            r_busy  <= n_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok.valid <= 1'b0;
        end else begin
            r_tok.valid <= n_tok.valid;
        end
        r_tok.kind   <= n_tok.kind;
        r_tok.col    <= n_tok.col;
        r_tok.row    <= n_tok.row;
        r_tok.value  <= n_tok.value;
        r_tok.px     <= n_tok.px;
        r_tok.py     <= n_tok.py;
        r_tok.number <= n_tok.number;
        r_tok.hit    <= n_tok.hit;
        r_tok.obj    <= n_tok.obj;
    end

    assign w_tok[0] = r_tok;

    // advance the token one cell per cycle; the first containing box wins
    for (genvar k = 0; k < MAX_BOXES; k++) begin : g_cell
        brm_cell #(
            .INDEX(k)
        ) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_clear(do_clear),
            .i_wr_en(do_append && (r_count == CNT_W'(k))),
            .i_box  (new_box),
            .i_tok  (w_tok[k]),
            .o_tok  (w_tok[k+1])
        );
    end

    assign last = w_tok[MAX_BOXES];

    // zero the fields that do not belong to the result kind, and the pixel and object number on a miss
    assign busy               = r_busy;
    assign o_strobe           = last.valid;
    assign o_result_kind      = last.kind;
    assign o_pixel_out        = (last.kind == KIND_PIXEL && last.hit) ? last.value : 8'd0;
    assign o_point_hit        = (last.kind == KIND_KEYPOINT) && last.hit;
    assign o_object_number    = (last.kind == KIND_KEYPOINT && last.hit) ? last.obj : '0;
    assign o_point_number_out = (last.kind == KIND_KEYPOINT) ? last.number : 16'd0;

endmodule
`default_nettype wire

// ----- sim/tb_box_region_mask_and_assign_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_box_region_mask_and_assign_top: self-checking bench for the box mask block
// Drives clear, append, pixel and keypoint commands through the start/busy
// handshake, tracks the box table in a small ledger class that predicts each
// query result, and checks every strobed result against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_box_region_mask_and_assign_top;
    import brm_pkg::*;

    localparam int FRAME_PIXELS = 1 << COORD_BITS;
    localparam int QUERY_CYCLES = MAX_BOXES_DEF + 1;
    localparam int STALL_LIMIT  = 2000;
    localparam int ITEM_TARGET  = 1750;

    // One command as presented on the input ports.
    typedef struct {
        logic [1:0]         command;
        logic signed [12:0] left;
        logic signed [12:0] top;
        logic [11:0]        span_x;
        logic [11:0]        span_y;
        logic [11:0]        col;
        logic [11:0]        row;
        logic [7:0]         value;
        logic [15:0]        px;
        logic [15:0]        py;
        logic [15:0]        number;
    } t_box_cmd;

    // One query result as seen on the output ports.
    typedef struct {
        logic             kind;
        logic [7:0]       pixel;
        logic             hit;
        logic [OBJ_W-1:0] obj;
        logic [15:0]      number;
    } t_query_result;

    // ------------------------------------------------------------------------
    // Box table shadow: notes every transfer, predicts query results and
    // checks what the block returns, oldest first.
    // ------------------------------------------------------------------------
    class box_ledger;
        t_box          boxes[MAX_BOXES_DEF];
        int unsigned   used;
        t_query_result expected_q[$];
        int unsigned   fail_count;

        function new();
            used       = 0;
            fail_count = 0;
        endfunction

        function int unsigned box_count();
            return used;
        endfunction

        function t_box box_at(int unsigned idx);
            return boxes[idx];
        endfunction

        function int unsigned outstanding();
            return expected_q.size();
        endfunction

        // Half-open bounds, box intersected with the frame.
        function bit pixel_kept(int col, int row);
            int k, l, t, x0, y0, x1, y1;
            bit kept;
            kept = (used == 0);
            for (k = 0; k < used && !kept; k++) begin
                l  = $signed(boxes[k].left);
                t  = $signed(boxes[k].top);
                x0 = (l < 0) ? 0 : l;
                y0 = (t < 0) ? 0 : t;
                x1 = l + int'(boxes[k].span_x);
                y1 = t + int'(boxes[k].span_y);
                if (x1 > FRAME_PIXELS) x1 = FRAME_PIXELS;
                if (y1 > FRAME_PIXELS) y1 = FRAME_PIXELS;
                kept = (col >= x0 && col < x1 && row >= y0 && row < y1);
            end
            return kept;
        endfunction

        // Returns 0 only for an append that a full table drops.
        function bit note_transfer(t_box_cmd it);
            t_query_result r;
            int k, l, t, px, py;
            r = '{kind: KIND_PIXEL, pixel: 8'd0, hit: 1'b0, obj: '0, number: 16'd0};
            case (it.command)
                CMD_CLEAR: begin
                    used = 0;
                end
                CMD_APPEND: begin
                    if (used == MAX_BOXES_DEF) return 1'b0;
                    boxes[used].left   = it.left;
                    boxes[used].top    = it.top;
                    boxes[used].span_x = it.span_x;
                    boxes[used].span_y = it.span_y;
                    used++;
                end
                CMD_PIXEL: begin
                    if (pixel_kept(int'(it.col), int'(it.row))) r.pixel = it.value;
                    expected_q.insert(expected_q.size(), r);
                end
                default: begin
                    // Keypoint: inclusive, unclipped bounds in 1/16 pixel.
                    r.kind   = KIND_KEYPOINT;
                    r.number = it.number;
                    px = int'(it.px);
                    py = int'(it.py);
                    for (k = 0; k < used && !r.hit; k++) begin
                        l = $signed(boxes[k].left);
                        t = $signed(boxes[k].top);
                        if (px >= l * 16 && px <= (l + int'(boxes[k].span_x)) * 16 &&
                            py >= t * 16 && py <= (t + int'(boxes[k].span_y)) * 16) begin
                            r.hit = 1'b1;
                            r.obj = k[OBJ_W-1:0];
                        end
                    end
                    expected_q.insert(expected_q.size(), r);
                end
            endcase
            return 1'b1;
        endfunction

        function void compare_field(string name, int unsigned want, int unsigned got);
            if (want != got) begin
                $error("%s mismatch: expected %0d, actual %0d", name, want, got);
                fail_count++;
            end
        endfunction

        function void check_result(t_query_result got);
            t_query_result want;
            if (expected_q.size() == 0) begin
                $error("result strobe with no query outstanding");
                fail_count++;
                return;
            end
            want = expected_q.pop_front();
            compare_field("result_kind", want.kind, got.kind);
            compare_field("pixel_out", want.pixel, got.pixel);
            compare_field("point_hit", want.hit, got.hit);
            compare_field("object_number", want.obj, got.obj);
            compare_field("point_number_out", want.number, got.number);
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset and the ports. Every input starts at a known value.
    // ------------------------------------------------------------------------
    logic               i_clk;
    logic               i_rst_n            = 1'b0;
    logic               start              = 1'b0;
    logic               busy;
    logic [1:0]         i_command          = CMD_CLEAR;
    logic signed [12:0] i_box_left         = '0;
    logic signed [12:0] i_box_top          = '0;
    logic [11:0]        i_box_span_x       = '0;
    logic [11:0]        i_box_span_y       = '0;
    logic [11:0]        i_pixel_column     = '0;
    logic [11:0]        i_pixel_row        = '0;
    logic [7:0]         i_pixel_value      = '0;
    logic [15:0]        i_point_x          = '0;
    logic [15:0]        i_point_y          = '0;
    logic [15:0]        i_point_number     = '0;
    logic               o_strobe;
    logic               o_result_kind;
    logic [7:0]         o_pixel_out;
    logic               o_point_hit;
    logic [OBJ_W-1:0]   o_object_number;
    logic [15:0]        o_point_number_out;

    box_ledger     ledger;
    t_query_result seen;
    int unsigned   effective_items = 0;
    int unsigned   burst_left      = 0;
    int unsigned   quiet_cycles    = 0;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    box_region_mask_and_assign_top uut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .start              (start),
        .busy               (busy),
        .i_command          (i_command),
        .i_box_left         (i_box_left),
        .i_box_top          (i_box_top),
        .i_box_span_x       (i_box_span_x),
        .i_box_span_y       (i_box_span_y),
        .i_pixel_column     (i_pixel_column),
        .i_pixel_row        (i_pixel_row),
        .i_pixel_value      (i_pixel_value),
        .i_point_x          (i_point_x),
        .i_point_y          (i_point_y),
        .i_point_number     (i_point_number),
        .o_strobe           (o_strobe),
        .o_result_kind      (o_result_kind),
        .o_pixel_out        (o_pixel_out),
        .o_point_hit        (o_point_hit),
        .o_object_number    (o_object_number),
        .o_point_number_out (o_point_number_out)
    );

    // Capture each result in the cycle its strobe is high; the block cannot
    // be stalled, so every strobed cycle is a transfer.
    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) begin
            seen.kind   = o_result_kind;
            seen.pixel  = o_pixel_out;
            seen.hit    = o_point_hit;
            seen.obj    = o_object_number;
            seen.number = o_point_number_out;
            ledger.check_result(seen);
        end
    end

    // Watchdog: count cycles in which neither side transfers anything.
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_strobe) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == STALL_LIMIT) begin
            $display("box_region_mask_and_assign_top verification failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // Item builders. Fields that a command does not use stay random so that
    // every input bit toggles.
    // ------------------------------------------------------------------------
    function automatic t_box_cmd noise_item();
        t_box_cmd it;
        it.command = 2'($urandom_range(0, 3));
        it.left    = 13'($urandom);
        it.top     = 13'($urandom);
        it.span_x  = 12'($urandom);
        it.span_y  = 12'($urandom);
        it.col     = 12'($urandom);
        it.row     = 12'($urandom);
        it.value   = 8'($urandom);
        it.px      = 16'($urandom);
        it.py      = 16'($urandom);
        it.number  = 16'($urandom);
        return it;
    endfunction

    function automatic t_box_cmd mk_clear();
        t_box_cmd it;
        it = noise_item();
        it.command = CMD_CLEAR;
        return it;
    endfunction

    function automatic t_box_cmd mk_append(int l, int t, int sx, int sy);
        t_box_cmd it;
        it = noise_item();
        it.command = CMD_APPEND;
        it.left    = l[12:0];
        it.top     = t[12:0];
        it.span_x  = sx[11:0];
        it.span_y  = sy[11:0];
        return it;
    endfunction

    function automatic t_box_cmd mk_pixel(int c, int r, int v);
        t_box_cmd it;
        it = noise_item();
        it.command = CMD_PIXEL;
        it.col     = c[11:0];
        it.row     = r[11:0];
        it.value   = v[7:0];
        return it;
    endfunction

    function automatic t_box_cmd mk_point(int x, int y, int n);
        t_box_cmd it;
        it = noise_item();
        it.command = CMD_KEYPOINT;
        it.px      = x[15:0];
        it.py      = y[15:0];
        it.number  = n[15:0];
        return it;
    endfunction

    // Box edges: mostly on the frame, some just left of it, some anywhere.
    function automatic int pick_edge();
        case ($urandom_range(0, 3))
            0:       return int'($urandom_range(0, 8191)) - 4096;
            1:       return -int'($urandom_range(1, 300));
            default: return int'($urandom_range(0, 4095));
        endcase
    endfunction

    function automatic int pick_span();
        case ($urandom_range(0, 5))
            0:       return 0;
            1:       return int'($urandom_range(0, 4095));
            default: return int'($urandom_range(1, 400));
        endcase
    endfunction

    function automatic t_box_cmd random_box();
        return mk_append(pick_edge(), pick_edge(), pick_span(), pick_span());
    endfunction

    // Coordinate near a box edge or inside it; scale 1 for pixels, 16 for
    // keypoints. Straddle both edges by one unit to hit the bound cases.
    function automatic int near_box(int origin, int span, int scale);
        case ($urandom_range(0, 3))
            0:       return origin * scale - 1 + int'($urandom_range(0, 2));
            1:       return (origin + span) * scale - 1 + int'($urandom_range(0, 2));
            default: return origin * scale + int'($urandom_range(0, span * scale));
        endcase
    endfunction

    function automatic int clamp_frame(int v);
        if (v < 0) return 0;
        if (v > FRAME_PIXELS - 1) return FRAME_PIXELS - 1;
        return v;
    endfunction

    function automatic t_box_cmd aimed_query(bit keypoint);
        t_box_cmd it;
        t_box b;
        int x, y;
        it = noise_item();
        it.command = keypoint ? CMD_KEYPOINT : CMD_PIXEL;
        if (ledger.box_count() != 0 && $urandom_range(0, 9) < 8) begin
            b = ledger.box_at($urandom_range(0, ledger.box_count() - 1));
            if (keypoint) begin
                x = near_box($signed(b.left), int'(b.span_x), 16);
                y = near_box($signed(b.top), int'(b.span_y), 16);
                it.px = x[15:0];
                it.py = y[15:0];
            end else begin
                x = clamp_frame(near_box($signed(b.left), int'(b.span_x), 1));
                y = clamp_frame(near_box($signed(b.top), int'(b.span_y), 1));
                it.col = x[11:0];
                it.row = y[11:0];
            end
        end
        return it;
    endfunction

    // ------------------------------------------------------------------------
    // Driving tasks
    // ------------------------------------------------------------------------

    // Drop start for a gap; with drain set, hold it low until every
    // outstanding query has returned. Callers always pass a nonzero gap.
    task automatic pause_sender(input int unsigned cycles, input bit drain);
        start <= 1'b0;
        if (drain) begin
            while (ledger.outstanding() != 0) @(posedge i_clk);
        end
        repeat (cycles) @(posedge i_clk);
    endtask

    // Present one command and hold it until the transfer edge; start stays
    // high afterwards unless a gap is drawn, so bursts run back to back.
    task automatic send_item(input t_box_cmd it);
        i_command      <= it.command;
        i_box_left     <= it.left;
        i_box_top      <= it.top;
        i_box_span_x   <= it.span_x;
        i_box_span_y   <= it.span_y;
        i_pixel_column <= it.col;
        i_pixel_row    <= it.row;
        i_pixel_value  <= it.value;
        i_point_x      <= it.px;
        i_point_y      <= it.py;
        i_point_number <= it.number;
        start          <= 1'b1;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        if (ledger.note_transfer(it)) effective_items++;
        if (burst_left > 1) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(1, 40);
            if ($urandom_range(0, 3) != 0) pause_sender($urandom_range(1, 20), 1'b0);
        end
    endtask

    // One scene: usually a clear, a batch of boxes (sometimes past a full
    // table), then a run of queries aimed mostly at the stored boxes.
    task automatic run_scene(input int unsigned min_boxes);
        int unsigned n_boxes, n_queries;
        if ($urandom_range(0, 7) != 0) send_item(mk_clear());
        n_boxes = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 3) : $urandom_range(1, 20);
        if (n_boxes < min_boxes) n_boxes = min_boxes;
        repeat (n_boxes) send_item(random_box());
        n_queries = $urandom_range(4, 30);
        repeat (n_queries) send_item(aimed_query($urandom_range(0, 1)));
    endtask

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin
        ledger     = new();
        burst_left = $urandom_range(1, 40);
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Empty table: pixels pass unchanged, keypoints miss.
        send_item(mk_pixel(4095, 0, 255));
        send_item(mk_point(65535, 0, 65535));
        // Box with negative origin, zero-span box, box running off the frame,
        // box at the most negative corner.
        send_item(mk_append(-10, -5, 20, 10));
        send_item(mk_append(100, 100, 0, 0));
        send_item(mk_append(4000, 4090, 4095, 4095));
        send_item(mk_append(-4096, -4096, 4095, 4095));
        // Clipped box keeps columns 0..9 only; right edge is exclusive.
        send_item(mk_pixel(9, 4, 8'hff));
        send_item(mk_pixel(10, 4, 8'h7e));
        send_item(mk_pixel(0, 0, 8'h81));
        // Zero-span box covers no pixel but still matches its keypoint.
        send_item(mk_pixel(100, 100, 8'hff));
        send_item(mk_point(1600, 1600, 16'h1234));
        // Inclusive keypoint corner of the first box, and one past it.
        send_item(mk_point(160, 80, 16'h8001));
        send_item(mk_point(161, 80, 16'h0002));
        // Far frame corner and the largest keypoint.
        send_item(mk_pixel(4095, 4095, 8'ha5));
        send_item(mk_point(65535, 65535, 0));
        send_item(mk_pixel(3999, 4095, 8'h5a));
        // Clear empties the table again.
        send_item(mk_clear());
        send_item(mk_pixel(1, 1, 8'h3c));
        send_item(mk_point(0, 0, 16'hbeef));
        // Full-frame box: last column is outside by the half-open bound.
        send_item(mk_append(0, 0, 4095, 4095));
        send_item(mk_pixel(4094, 4094, 8'hc3));
        send_item(mk_pixel(4095, 0, 8'hff));

        // Let the pipeline run dry once before the random part.
        pause_sender(3, 1'b1);
        run_scene(20);
        while (effective_items < ITEM_TARGET) begin
            if ($urandom_range(0, 9) == 0) pause_sender($urandom_range(1, 4), 1'b1);
            if ($urandom_range(0, 9) == 0) begin
                repeat ($urandom_range(3, 12)) send_item(noise_item());
            end else begin
                run_scene(0);
            end
        end
        start <= 1'b0;

        // Drain, then keep the clock running for stray strobes before the verdict.
        while (ledger.outstanding() != 0) @(posedge i_clk);
        repeat (2 * QUERY_CYCLES) @(posedge i_clk);
        if (ledger.fail_count == 0 && ledger.outstanding() == 0) begin
            $display("box_region_mask_and_assign_top verification clean");
        end else begin
            $display("box_region_mask_and_assign_top verification failed");
        end
        $finish;
    end

endmodule
